// ===== rtl/fhcc_pkg.sv =====
// Shared types, constants and helpers for the file header content classifier.
package fhcc_pkg;

   localparam int BYTE_W           = 8;
   localparam int THRESH_W         = 7;
   localparam int HEADER_BYTES_DEF = 512;
   localparam int QUEUE_DEPTH_DEF  = 2;
   localparam int KEY_BYTES        = 8;
   localparam int IOFF_W           = 10;
   localparam int ILEN_W           = 9;
   localparam int PERCENT_SCALE    = 100;
   localparam int ELF_MIN_BYTES    = 16;
   localparam int ELF_TYPE_BYTES   = 18;
   localparam int HDR_LEAD_BYTES   = 6;
   localparam int HDR_TYPE_LO_POS  = 16;
   localparam int HDR_TYPE_HI_POS  = 17;
   localparam int INTERP_START_POS = 2;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd80;

   localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7f;
   localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
   localparam logic [BYTE_W-1:0] CH_L     = 8'h4c;
   localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
   localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_FF    = 8'h0c;
   localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7e;

   localparam logic [BYTE_W-1:0] ELF_CODE_1 = 8'h01;
   localparam logic [BYTE_W-1:0] ELF_CODE_2 = 8'h02;
   localparam logic [BYTE_W-1:0] ELF_CODE_3 = 8'h03;

   typedef enum logic [1:0] {
      KIND_ELF    = 2'd0,
      KIND_SCRIPT = 2'd1,
      KIND_TEXT   = 2'd2,
      KIND_DATA   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CLS_NONE = 2'd0,
      CLS_32   = 2'd1,
      CLS_64   = 2'd2
   } elf_class_type;

   typedef enum logic [1:0] {
      ORD_NONE = 2'd0,
      ORD_LSB  = 2'd1,
      ORD_MSB  = 2'd2
   } elf_order_type;

   typedef enum logic [1:0] {
      OTYPE_REL  = 2'd0,
      OTYPE_EXEC = 2'd1,
      OTYPE_DYN  = 2'd2,
      OTYPE_OBJ  = 2'd3
   } elf_otype_type;

   // one classified file; kind KIND_DATA here means the text ratio decides
   typedef struct packed {
      kind_type             kind;
      elf_class_type        elf_class;
      elf_order_type        elf_byte_order;
      elf_otype_type        elf_object_type;
      logic [IOFF_W-1:0]    interp_offset;
      logic [ILEN_W-1:0]    interp_length;
   } summ_type;

   function automatic logic is_text(input logic [BYTE_W-1:0] b);
      is_text = (b >= CH_SPACE && b <= CH_TILDE) || b == CH_LF || b == CH_CR ||
                b == CH_TAB || b == CH_FF;
   endfunction

endpackage

// ===== rtl/fhcc_if.sv =====
// Channel interfaces: byte input, classification result and threshold write.
interface fhcc_req_if;
   import fhcc_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface fhcc_rsp_if;
   import fhcc_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        content_kind;
   logic [1:0]        elf_class;
   logic [1:0]        elf_byte_order;
   logic [1:0]        elf_object_type;
   logic [IOFF_W-1:0] interp_offset;
   logic [ILEN_W-1:0] interp_length;
   modport source (output valid, content_kind, elf_class, elf_byte_order, elf_object_type,
                   interp_offset, interp_length, input ready);
   modport sink   (input valid, content_kind, elf_class, elf_byte_order, elf_object_type,
                   interp_offset, interp_length, output ready);
endinterface

interface fhcc_csr_if;
   import fhcc_pkg::*;
   logic                valid;
   logic                ready;
   logic [THRESH_W-1:0] text_percent_threshold;
   modport source (output valid, text_percent_threshold, input ready);
   modport sink   (input valid, text_percent_threshold, output ready);
endinterface

// ===== rtl/fhcc_front.sv =====
// Front end: accumulates per-file header state and classifies on the last byte.
module fhcc_front #(
   parameter int HEADER_BYTES = fhcc_pkg::HEADER_BYTES_DEF,
   parameter int CNT_W        = $clog2(HEADER_BYTES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   fhcc_req_if.sink           req_ch,
   output logic               push_valid,
   input  logic               push_ready,
   output fhcc_pkg::summ_type push_summ,
   output logic [CNT_W-1:0]   push_text,
   output logic [CNT_W-1:0]   push_bytes
);
   import fhcc_pkg::*;

   typedef enum logic [1:0] {
      PH_SKIP = 2'd0,
      PH_NAME = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   logic [CNT_W-1:0]  bytes_ff, bytes_in;
   logic [CNT_W-1:0]  text_ff, text_in;
   logic [BYTE_W-1:0] hdr_ff [KEY_BYTES];
   logic [BYTE_W-1:0] hdr_in [KEY_BYTES];
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  begin_ff, begin_in;
   logic [CNT_W-1:0]  end_ff, end_in;

   logic              accept;
   logic              take;
   logic              eol;
   logic [BYTE_W-1:0] b;
   logic [CNT_W-1:0]  pos;
   logic [2*BYTE_W-1:0] etype;
   summ_type          summ;

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.data_byte;
   assign pos          = bytes_ff;
   assign take         = bytes_ff < CNT_W'(HEADER_BYTES);
   assign eol          = (b == CH_LF) || (b == CH_CR);

   always_comb begin
      bytes_in = bytes_ff;
      text_in  = text_ff;
      hdr_in   = hdr_ff;
      phase_in = phase_ff;
      begin_in = begin_ff;
      end_in   = end_ff;
      if (take) begin
         if (pos < CNT_W'(HDR_LEAD_BYTES)) begin
            hdr_in[pos[2:0]] = b;
         end else if (pos == CNT_W'(HDR_TYPE_LO_POS)) begin
            hdr_in[6] = b;
         end else if (pos == CNT_W'(HDR_TYPE_HI_POS)) begin
            hdr_in[7] = b;
         end
         text_in = text_ff + CNT_W'(is_text(b));
         if (pos >= CNT_W'(INTERP_START_POS)) begin
            unique case (phase_ff)
               PH_SKIP: begin
                  if (b != CH_SPACE) begin
                     begin_in = pos;
                     if (eol) begin
                        end_in   = pos;
                        phase_in = PH_DONE;
                     end else begin
                        end_in   = pos + CNT_W'(1);
                        phase_in = PH_NAME;
                     end
                  end
               end
               PH_NAME: begin
                  if (eol) begin
                     phase_in = PH_DONE;
                  end else begin
                     end_in = pos + CNT_W'(1);
                  end
               end
               default: ;
            endcase
         end
         bytes_in = bytes_ff + CNT_W'(1);
      end
   end

   assign etype = {hdr_in[7], hdr_in[6]};

   always_comb begin
      summ = '0;
      if (bytes_in >= CNT_W'(ELF_MIN_BYTES) && hdr_in[0] == CH_DEL && hdr_in[1] == CH_E &&
          hdr_in[2] == CH_L && hdr_in[3] == CH_F) begin
         summ.kind = KIND_ELF;
         if (hdr_in[4] == ELF_CODE_1) begin
            summ.elf_class = CLS_32;
         end else if (hdr_in[4] == ELF_CODE_2) begin
            summ.elf_class = CLS_64;
         end
         if (hdr_in[5] == ELF_CODE_1) begin
            summ.elf_byte_order = ORD_LSB;
         end else if (hdr_in[5] == ELF_CODE_2) begin
            summ.elf_byte_order = ORD_MSB;
         end
         summ.elf_object_type = OTYPE_OBJ;
         if (bytes_in >= CNT_W'(ELF_TYPE_BYTES) && hdr_in[5] == ELF_CODE_1) begin
            if (etype == {8'h00, ELF_CODE_1}) begin
               summ.elf_object_type = OTYPE_REL;
            end else if (etype == {8'h00, ELF_CODE_2}) begin
               summ.elf_object_type = OTYPE_EXEC;
            end else if (etype == {8'h00, ELF_CODE_3}) begin
               summ.elf_object_type = OTYPE_DYN;
            end
         end
      end else if (bytes_in >= CNT_W'(INTERP_START_POS) && hdr_in[0] == CH_HASH &&
                   hdr_in[1] == CH_BANG) begin
         summ.kind = KIND_SCRIPT;
         if (phase_in == PH_SKIP) begin
            summ.interp_offset = IOFF_W'(bytes_in);
         end else begin
            summ.interp_offset = IOFF_W'(begin_in);
            summ.interp_length = ILEN_W'(end_in - begin_in);
         end
      end else begin
         summ.kind = KIND_DATA;
      end
   end

   assign push_valid = accept && req_ch.last_byte;
   assign push_summ  = summ;
   assign push_text  = text_in;
   assign push_bytes = bytes_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= '0;
         text_ff  <= '0;
         hdr_ff   <= '{default: '0};
         phase_ff <= PH_SKIP;
         begin_ff <= '0;
         end_ff   <= '0;
      end else if (accept) begin
         if (req_ch.last_byte) begin
            bytes_ff <= '0;
            text_ff  <= '0;
            hdr_ff   <= '{default: '0};
            phase_ff <= PH_SKIP;
            begin_ff <= '0;
            end_ff   <= '0;
         end else begin
            bytes_ff <= bytes_in;
            text_ff  <= text_in;
            hdr_ff   <= hdr_in;
            phase_ff <= phase_in;
            begin_ff <= begin_in;
            end_ff   <= end_in;
         end
      end
   end

endmodule

// ===== rtl/fhcc_queue.sv =====
// Small FIFO between the front end and the back end.
module fhcc_queue #(
   parameter int DEPTH  = fhcc_pkg::QUEUE_DEPTH_DEF,
   parameter int DATA_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ff;
   logic [PTR_W-1:0]  rd_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              push, pop;

   assign push_ready = cnt_ff != CNT_W'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ===== rtl/fhcc_back.sv =====
// Back end: text ratio decision, threshold register and result output register.
module fhcc_back #(
   parameter int CNT_W = 10
) (
   input  logic               clock,
   input  logic               reset,
   fhcc_csr_if.sink           csr_ch,
   fhcc_rsp_if.source         rsp_ch,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  fhcc_pkg::summ_type pop_summ,
   input  logic [CNT_W-1:0]   pop_text,
   input  logic [CNT_W-1:0]   pop_bytes
);
   import fhcc_pkg::*;

   localparam int PROD_W = CNT_W + THRESH_W + 1;

   logic [THRESH_W-1:0] thr_ff;
   logic                s1_valid_ff;
   summ_type            s1_summ_ff;
   logic [PROD_W-1:0]   s1_text_ff;
   logic [PROD_W-1:0]   s1_lim_ff;
   logic                out_valid_ff;
   summ_type            out_summ_ff, out_summ_in;
   logic                s1_load, s2_load;
   kind_type            kind_in;

   assign csr_ch.ready = 1'b1;

   assign s2_load   = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign s1_load   = pop_valid && (!s1_valid_ff || s2_load);
   assign pop_ready = !s1_valid_ff || s2_load;

   // floor(100*t/n) > thr  <=>  100*t >= (thr+1)*n
   always_comb begin
      kind_in = s1_summ_ff.kind;
      if (s1_summ_ff.kind == KIND_DATA) begin
         kind_in = (s1_text_ff >= s1_lim_ff) ? KIND_TEXT : KIND_DATA;
      end
      out_summ_in      = s1_summ_ff;
      out_summ_in.kind = kind_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESH_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         thr_ff <= csr_ch.text_percent_threshold;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_summ_ff <= pop_summ;
         s1_text_ff <= PROD_W'(pop_text) * PROD_W'(PERCENT_SCALE);
         s1_lim_ff  <= PROD_W'({1'b0, thr_ff} + 8'd1) * PROD_W'(pop_bytes);
      end
      if (s2_load) begin
         out_summ_ff <= out_summ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.content_kind    = out_summ_ff.kind;
   assign rsp_ch.elf_class       = out_summ_ff.elf_class;
   assign rsp_ch.elf_byte_order  = out_summ_ff.elf_byte_order;
   assign rsp_ch.elf_object_type = out_summ_ff.elf_object_type;
   assign rsp_ch.interp_offset   = out_summ_ff.interp_offset;
   assign rsp_ch.interp_length   = out_summ_ff.interp_length;

endmodule

// ===== rtl/file_header_content_classifier_top.sv =====
// Top level of the file header content classifier.
//
//  channel  | dir | payload                                   | transaction
//  req_ch   | in  | data_byte, last_byte                      | one file byte
//  rsp_ch   | out | content_kind, elf_*, interp_offset/length | one file result
//  csr_ch   | in  | text_percent_threshold                    | threshold write
//
// One byte is taken per cycle while the queue has room; a result passes the queue
// write, product stage and output register after the transaction carrying last_byte.
// Reset is synchronous: file state clears and the threshold returns to 80.
// A stalled rsp_ch fills the back end and then the queue; req_ch.ready drops
// only while the queue is full.
module file_header_content_classifier_top #(
   parameter int HEADER_BYTES = fhcc_pkg::HEADER_BYTES_DEF,
   parameter int QUEUE_DEPTH  = fhcc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   fhcc_req_if.sink   req_ch,
   fhcc_rsp_if.source rsp_ch,
   fhcc_csr_if.sink   csr_ch
);
   import fhcc_pkg::*;

   localparam int CNT_W  = $clog2(HEADER_BYTES + 1);
   localparam int ENTRY_W = $bits(summ_type) + 2 * CNT_W;

   logic               push_valid, push_ready;
   summ_type           push_summ;
   logic [CNT_W-1:0]   push_text, push_bytes;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;
   summ_type           pop_summ;
   logic [CNT_W-1:0]   pop_text, pop_bytes;

   fhcc_front #(
      .HEADER_BYTES (HEADER_BYTES),
      .CNT_W        (CNT_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_summ  (push_summ),
      .push_text  (push_text),
      .push_bytes (push_bytes)
   );

   fhcc_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_summ, push_text, push_bytes}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_summ, pop_text, pop_bytes} = pop_data;

   fhcc_back #(
      .CNT_W (CNT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_summ  (pop_summ),
      .pop_text  (pop_text),
      .pop_bytes (pop_bytes)
   );

endmodule

// ===== rtl/fhcc_checker.sv =====
// Port-level assertions for the classifier top level, with its bind.
module fhcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] content_kind,
   input logic [1:0] elf_class,
   input logic [1:0] elf_byte_order,
   input logic [1:0] elf_object_type,
   input logic [9:0] interp_offset,
   input logic [8:0] interp_length
);
   import fhcc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(content_kind) &&
      $stable(interp_offset) && $stable(interp_length))
      else $error("result changed while stalled");

   a_elf_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && content_kind != KIND_ELF |->
      elf_class == CLS_NONE && elf_byte_order == ORD_NONE && elf_object_type == OTYPE_REL)
      else $error("ELF fields set on non-ELF result");

   a_script_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && content_kind != KIND_SCRIPT |-> interp_offset == '0 && interp_length == '0)
      else $error("interpreter fields set on non-script result");

   a_elf_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> elf_class != 2'd3 && elf_byte_order != 2'd3)
      else $error("undefined ELF class or byte order code");

endmodule

bind file_header_content_classifier_top fhcc_checker u_fhcc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .content_kind    (rsp_ch.content_kind),
   .elf_class       (rsp_ch.elf_class),
   .elf_byte_order  (rsp_ch.elf_byte_order),
   .elf_object_type (rsp_ch.elf_object_type),
   .interp_offset   (rsp_ch.interp_offset),
   .interp_length   (rsp_ch.interp_length)
);

// ===== tb/tb_file_header_content_classifier_top.sv =====
// Self-checking testbench: streams file headers byte by byte and checks each classification.
module tb_file_header_content_classifier_top;
   import fhcc_pkg::*;

   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 6;
   localparam int RANDOM_BYTES = 80;

   typedef enum logic [1:0] {
      NAME_SKIP,
      NAME_INSIDE,
      NAME_DONE
   } name_phase_type;

   logic clock;
   logic reset;

   fhcc_req_if req_ch();
   fhcc_rsp_if rsp_ch();
   fhcc_csr_if csr_ch();

   file_header_content_classifier_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   logic [IOFF_W-1:0]   hdr_count;
   logic [IOFF_W-1:0]   text_count;
   logic [BYTE_W-1:0]   key_bytes [KEY_BYTES];
   name_phase_type      name_phase;
   logic [IOFF_W-1:0]   name_begin;
   logic [IOFF_W-1:0]   name_end;
   logic [THRESH_W-1:0] threshold_now;

   summ_type            expected_summaries [$];
   logic [BYTE_W-1:0]   file_buf [$];

   int mismatch_count = 0;
   int files_checked  = 0;
   int bytes_sent     = 0;
   int csr_writes     = 0;
   int kind_seen [4]  = '{0, 0, 0, 0};

   bit req_steady = 0;
   bit rsp_steady = 0;
   bit rsp_hold   = 0;
   int rsp_stall_left = 0;
   int rsp_roll;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic bit text_byte(input logic [BYTE_W-1:0] b);
      return b inside {[CH_SPACE:CH_TILDE], CH_LF, CH_CR, CH_TAB, CH_FF};
   endfunction

   function automatic logic [BYTE_W-1:0] rand_text_byte();
      case ($urandom_range(0, 19))
         0: return CH_LF;
         1: return CH_CR;
         2: return CH_TAB;
         3: return CH_FF;
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] rand_binary_byte();
      logic [BYTE_W-1:0] b;
      do b = 8'($urandom); while (text_byte(b));
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_code();
      int roll;
      roll = $urandom_range(0, 4);
      if (roll < 4) return 8'(roll);
      return 8'($urandom);
   endfunction

   function automatic int pick_gap();
      int roll;
      if (req_steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic clear_file_state();
      hdr_count  = '0;
      text_count = '0;
      foreach (key_bytes[i]) key_bytes[i] = '0;
      name_phase = NAME_SKIP;
      name_begin = '0;
      name_end   = '0;
   endtask

   // advance the predictor by one accepted byte; queue a summary on the last one
   task automatic classify_byte(input logic [BYTE_W-1:0] b, input logic last);
      summ_type r;
      int       pos;
      int       pct;
      int       etype;
      logic     eol;
      if (hdr_count < HEADER_BYTES_DEF) begin
         pos = int'(hdr_count);
         if (pos < HDR_LEAD_BYTES) key_bytes[pos] = b;
         else if (pos == HDR_TYPE_LO_POS) key_bytes[6] = b;
         else if (pos == HDR_TYPE_HI_POS) key_bytes[7] = b;
         if (text_byte(b)) text_count++;
         if (pos >= INTERP_START_POS) begin
            eol = (b == CH_LF || b == CH_CR);
            case (name_phase)
               NAME_SKIP: begin
                  if (b != CH_SPACE) begin
                     name_begin = IOFF_W'(pos);
                     if (eol) begin
                        name_end   = IOFF_W'(pos);
                        name_phase = NAME_DONE;
                     end else begin
                        name_end   = IOFF_W'(pos + 1);
                        name_phase = NAME_INSIDE;
                     end
                  end
               end
               NAME_INSIDE: begin
                  if (eol) name_phase = NAME_DONE;
                  else name_end = IOFF_W'(pos + 1);
               end
               default: ;
            endcase
         end
         hdr_count = IOFF_W'(pos + 1);
      end
      if (!last) return;

      r = '0;
      if (hdr_count >= ELF_MIN_BYTES && key_bytes[0] == CH_DEL && key_bytes[1] == CH_E &&
          key_bytes[2] == CH_L && key_bytes[3] == CH_F) begin
         r.kind = KIND_ELF;
         r.elf_class = (key_bytes[4] == ELF_CODE_1) ? CLS_32 :
                       (key_bytes[4] == ELF_CODE_2) ? CLS_64 : CLS_NONE;
         r.elf_byte_order = (key_bytes[5] == ELF_CODE_1) ? ORD_LSB :
                            (key_bytes[5] == ELF_CODE_2) ? ORD_MSB : ORD_NONE;
         r.elf_object_type = OTYPE_OBJ;
         if (hdr_count >= ELF_TYPE_BYTES && key_bytes[5] == ELF_CODE_1) begin
            etype = int'({key_bytes[7], key_bytes[6]});
            case (etype)
               1: r.elf_object_type = OTYPE_REL;
               2: r.elf_object_type = OTYPE_EXEC;
               3: r.elf_object_type = OTYPE_DYN;
               default: ;
            endcase
         end
      end else if (hdr_count >= 2 && key_bytes[0] == CH_HASH && key_bytes[1] == CH_BANG) begin
         r.kind = KIND_SCRIPT;
         if (name_phase == NAME_SKIP) begin
            r.interp_offset = hdr_count;
         end else begin
            r.interp_offset = name_begin;
            r.interp_length = ILEN_W'(name_end - name_begin);
         end
      end else begin
         pct = (int'(text_count) * PERCENT_SCALE) / int'(hdr_count);
         r.kind = (pct > int'(threshold_now)) ? KIND_TEXT : KIND_DATA;
      end
      expected_summaries.push_back(r);
      clear_file_state();
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      bytes_sent++;
      classify_byte(b, last);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_buf.size(); i++)
         send_byte(file_buf[i], i == file_buf.size() - 1);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      wait_idle();
      csr_ch.valid                  <= 1'b1;
      csr_ch.text_percent_threshold <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid  <= 1'b0;
      threshold_now = value;
      csr_writes++;
   endtask

   task automatic build_random_file();
      int sel;
      int len;
      int share;
      sel = $urandom_range(0, 9);
      file_buf.delete();
      case (sel)
         0, 1, 2: begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 19) : $urandom_range(18, 48);
            file_buf = {CH_DEL, CH_E, CH_L, CH_F, pick_code(), pick_code()};
            while (file_buf.size() < len) file_buf.push_back(8'($urandom));
            if (len > HDR_TYPE_HI_POS) begin
               file_buf[HDR_TYPE_LO_POS] = pick_code();
               file_buf[HDR_TYPE_HI_POS] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
            end
            // broken magic
            if (sel == 2) file_buf[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
         end
         3, 4, 5: begin
            file_buf = {CH_HASH, CH_BANG};
            repeat ($urandom_range(0, 3)) file_buf.push_back(CH_SPACE);
            repeat ($urandom_range(0, 12)) file_buf.push_back(8'($urandom_range(33, 126)));
            case ($urandom_range(0, 2))
               0: file_buf.push_back(CH_LF);
               1: file_buf.push_back(CH_CR);
               default: ;
            endcase
            repeat ($urandom_range(0, 8)) file_buf.push_back(8'($urandom));
            if (sel == 5 && $urandom_range(0, 1) == 1) file_buf[1] = 8'($urandom);
         end
         6, 7: begin
            len   = $urandom_range(1, 40);
            share = $urandom_range(50, 100);
            repeat (len)
               file_buf.push_back(($urandom_range(1, 100) <= share) ? rand_text_byte()
                                                                    : rand_binary_byte());
         end
         default: begin
            repeat ($urandom_range(1, 30)) file_buf.push_back(8'($urandom));
         end
      endcase
   endtask

   // binary bytes first so the file cannot start as a script unless it is all text
   task automatic build_ratio_file(input int len, input int text_n);
      file_buf.delete();
      repeat (len - text_n) file_buf.push_back(rand_binary_byte());
      repeat (text_n) file_buf.push_back(rand_text_byte());
   endtask

   task automatic check_summary();
      summ_type exp;
      if (expected_summaries.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: kind %0d offset %0d length %0d",
                     rsp_ch.content_kind, rsp_ch.interp_offset, rsp_ch.interp_length);
         return;
      end
      exp = expected_summaries.pop_front();
      files_checked++;
      kind_seen[exp.kind]++;
      if (rsp_ch.content_kind !== exp.kind || rsp_ch.elf_class !== exp.elf_class ||
          rsp_ch.elf_byte_order !== exp.elf_byte_order ||
          rsp_ch.elf_object_type !== exp.elf_object_type ||
          rsp_ch.interp_offset !== exp.interp_offset ||
          rsp_ch.interp_length !== exp.interp_length) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("file %0d: exp %0d %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d %0d",
                     files_checked, exp.kind, exp.elf_class, exp.elf_byte_order,
                     exp.elf_object_type, exp.interp_offset, exp.interp_length,
                     rsp_ch.content_kind, rsp_ch.elf_class, rsp_ch.elf_byte_order,
                     rsp_ch.elf_object_type, rsp_ch.interp_offset, rsp_ch.interp_length);
      end
   endtask

   // result side: check each transaction, then pick the next ready value
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_summary();
         if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
         end else if (rsp_steady) begin
            rsp_ch.ready <= 1'b1;
         end else if (rsp_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_roll = $urandom_range(0, 99);
            if (rsp_roll < 70) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready   <= 1'b0;
               rsp_stall_left = (rsp_roll < 94) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            end
         end
      end
   end

   task automatic test_directed();
      file_buf = {8'h00};                      send_file();
      file_buf = {8'hff};                      send_file();
      file_buf = {8'h41};                      send_file();
      file_buf = {CH_HASH, CH_BANG};           send_file();
      file_buf = {CH_HASH, CH_BANG, CH_SPACE, CH_SPACE}; send_file();
      file_buf = {CH_HASH, CH_BANG, CH_LF};    send_file();
      file_buf = {CH_HASH, CH_BANG, CH_SPACE, 8'h73, 8'h68, CH_CR, 8'h78}; send_file();
      file_buf = {CH_HASH, CH_SPACE, CH_BANG}; send_file();
   endtask

   task automatic test_elf_headers();
      int len;
      for (int i = 0; i < 12; i++) begin
         len = (i == 0) ? ELF_MIN_BYTES - 1 : (i == 1) ? ELF_MIN_BYTES :
               (i == 2) ? ELF_TYPE_BYTES - 1 : ELF_TYPE_BYTES + $urandom_range(0, 6);
         file_buf = {CH_DEL, CH_E, CH_L, CH_F, 8'(i % 4), 8'((i / 4) % 3 == 0 ? 1 : i % 3)};
         while (file_buf.size() < len) file_buf.push_back(8'($urandom));
         if (len >= ELF_TYPE_BYTES) begin
            file_buf[HDR_TYPE_LO_POS] = 8'(i % 5);
            file_buf[HDR_TYPE_HI_POS] = (i == 11) ? 8'h01 : 8'h00;
         end
         send_file();
      end
   endtask

   task automatic test_long_files();
      // interpreter name runs to the end of the counted bytes, then ignored bytes
      file_buf = {CH_HASH, CH_BANG};
      repeat (HEADER_BYTES_DEF - 2) file_buf.push_back(8'($urandom_range(33, 126)));
      repeat (5) file_buf.push_back(8'($urandom));
      send_file();
      // only spaces after the marker
      file_buf = {CH_HASH, CH_BANG};
      repeat ($urandom_range(20, 40)) file_buf.push_back(CH_SPACE);
      send_file();
   endtask

   task automatic test_threshold_sweep();
      int levels [6];
      int shares [5];
      levels = '{0, 100, 101, 127, 37, int'(THRESH_RESET)};
      shares = '{0, 1, 8, 9, 10};
      foreach (levels[l]) begin
         write_threshold(THRESH_W'(levels[l]));
         foreach (shares[s]) begin
            build_ratio_file(10, shares[s]);
            send_file();
         end
         build_ratio_file(20, $urandom_range(5, 10));
         send_file();
      end
   endtask

   task automatic test_back_pressure();
      wait_idle();
      rsp_hold = 1;
      fork
         begin
            for (int i = 0; i < 10; i++) begin
               file_buf = {8'($urandom)};
               send_file();
            end
         end
         begin
            repeat (80) @(posedge clock);
            rsp_hold = 0;
         end
      join
      req_steady = 1;
      rsp_steady = 1;
      repeat (6) begin
         build_random_file();
         send_file();
      end
      req_steady = 0;
      rsp_steady = 0;
   endtask

   task automatic test_random_files();
      int stop_at;
      stop_at = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < stop_at) begin
         build_random_file();
         send_file();
         if ($urandom_range(0, 59) == 0) write_threshold(THRESH_W'($urandom_range(0, 127)));
      end
   endtask

   initial begin
      reset                         <= 1'b1;
      req_ch.valid                  <= 1'b0;
      req_ch.data_byte              <= '0;
      req_ch.last_byte              <= 1'b0;
      csr_ch.valid                  <= 1'b0;
      csr_ch.text_percent_threshold <= '0;
      clear_file_state();
      threshold_now = THRESH_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_elf_headers();
      test_long_files();
      test_threshold_sweep();
      test_back_pressure();
      test_random_files();
      write_threshold(THRESH_RESET);
      wait_idle();

      $display("covered %0d files in %0d bytes: %0d elf, %0d script, %0d text, %0d data",
               files_checked, bytes_sent, kind_seen[KIND_ELF], kind_seen[KIND_SCRIPT],
               kind_seen[KIND_TEXT], kind_seen[KIND_DATA]);
      $display("%0d threshold writes from 0 to 127, full header overrun, result back-pressure",
               csr_writes);
      if (mismatch_count == 0 && expected_summaries.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
